// ===== rtl/chfan_pkg.sv =====
package chfan_pkg;

   localparam int unsigned DataWidth = 12;

   // Configuration register indexes.
   localparam logic [2:0] REG_LOW_AMBIENT_THRESHOLD  = 3'd0;
   localparam logic [2:0] REG_HIGH_AMBIENT_THRESHOLD = 3'd1;
   localparam logic [2:0] REG_ENABLE_BELOW_SPEED     = 3'd2;
   localparam logic [2:0] REG_DISABLE_ABOVE_SPEED    = 3'd3;
   localparam logic [2:0] REG_LOW_AMB_ON_TEMP        = 3'd4;
   localparam logic [2:0] REG_HIGH_AMB_ON_TEMP       = 3'd5;
   localparam logic [2:0] REG_LOW_AMB_OFF_TEMP       = 3'd6;
   localparam logic [2:0] REG_HIGH_AMB_OFF_TEMP      = 3'd7;

   // Fan mode codes.
   localparam logic [1:0] MODE_OFF  = 2'd0;
   localparam logic [1:0] MODE_ON   = 2'd1;
   localparam logic [1:0] MODE_AUTO = 2'd2;

   // Status codes.
   localparam logic [1:0] STATUS_DISABLED = 2'd0;
   localparam logic [1:0] STATUS_OFF      = 2'd1;
   localparam logic [1:0] STATUS_AUTO     = 2'd2;
   localparam logic [1:0] STATUS_ON       = 2'd3;

   // Register reset values.
   localparam logic signed [DataWidth-1:0] RST_LOW_AMBIENT_THRESHOLD  = 12'sd300;
   localparam logic signed [DataWidth-1:0] RST_HIGH_AMBIENT_THRESHOLD = 12'sd350;
   localparam logic [DataWidth-1:0]        RST_ENABLE_BELOW_SPEED     = 12'd640;
   localparam logic [DataWidth-1:0]        RST_DISABLE_ABOVE_SPEED    = 12'd720;
   localparam logic signed [DataWidth-1:0] RST_LOW_AMB_ON_TEMP        = 12'sd950;
   localparam logic signed [DataWidth-1:0] RST_HIGH_AMB_ON_TEMP       = 12'sd900;
   localparam logic signed [DataWidth-1:0] RST_LOW_AMB_OFF_TEMP       = 12'sd820;
   localparam logic signed [DataWidth-1:0] RST_HIGH_AMB_OFF_TEMP      = 12'sd780;

   typedef struct packed {
      logic [DataWidth-1:0]        vehicle_speed;
      logic signed [DataWidth-1:0] engine_temp;
      logic signed [DataWidth-1:0] ambient_temp;
      logic                        engine_active;
      logic [1:0]                  fan_mode;
      logic                        force_on;
      logic                        fan_enabled;
   } req_type;

   typedef struct packed {
      logic       fan_drive;
      logic       high_ambient;
      logic [1:0] fan_status;
   } rsp_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] low_ambient_threshold;
      logic signed [DataWidth-1:0] high_ambient_threshold;
      logic [DataWidth-1:0]        enable_below_speed;
      logic [DataWidth-1:0]        disable_above_speed;
      logic signed [DataWidth-1:0] low_amb_on_temp;
      logic signed [DataWidth-1:0] high_amb_on_temp;
      logic signed [DataWidth-1:0] low_amb_off_temp;
      logic signed [DataWidth-1:0] high_amb_off_temp;
   } cfg_type;

   typedef struct packed {
      logic fan_running;
      logic high_ambient_mode;
   } state_type;

endpackage

// ===== rtl/chfan_step.sv =====
module chfan_step
   import chfan_pkg::*;
(
   input  req_type   word,
   input  cfg_type   cfg,
   input  state_type state,
   output state_type state_next,
   output rsp_type   result
);

   logic                        amb_high;
   logic                        running;
   logic                        run_next;
   logic                        on_speed;
   logic                        off_speed;
   logic                        on_temp;
   logic                        off_temp;
   logic signed [DataWidth-1:0] on_limit;
   logic signed [DataWidth-1:0] off_limit;
   logic [1:0]                  status;

   assign running = state.fan_running;

   // The ambient flag is updated first; the new value picks the temperature band.
   always_comb begin
      priority if (word.ambient_temp >= cfg.high_ambient_threshold) begin
         amb_high = 1'b1;
      end else if (word.ambient_temp < cfg.low_ambient_threshold) begin
         amb_high = 1'b0;
      end else begin
         amb_high = state.high_ambient_mode;
      end
   end

   assign on_limit  = amb_high ? cfg.high_amb_on_temp  : cfg.low_amb_on_temp;
   assign off_limit = amb_high ? cfg.high_amb_off_temp : cfg.low_amb_off_temp;

   assign on_speed  = (word.vehicle_speed < cfg.enable_below_speed) && !running;
   assign off_speed = (word.vehicle_speed >= cfg.disable_above_speed) && running;
   assign on_temp   = (word.engine_temp > on_limit) && !running;
   assign off_temp  = (word.engine_temp <= off_limit) && running;

   always_comb begin
      run_next = running;
      status   = STATUS_DISABLED;
      unique case (word.fan_mode)
         MODE_OFF: begin
            run_next = word.force_on && word.fan_enabled;
            status   = STATUS_OFF;
         end
         MODE_ON: begin
            if ((on_speed && word.engine_active) || word.force_on) begin
               run_next = 1'b1;
            end else if (off_speed || (!word.engine_active && running)) begin
               run_next = 1'b0;
            end
            status = STATUS_ON;
         end
         MODE_AUTO: begin
            if ((on_speed && on_temp) || word.force_on) begin
               run_next = 1'b1;
            end else if (off_speed || off_temp || (!word.engine_active && running)) begin
               run_next = 1'b0;
            end
            status = STATUS_AUTO;
         end
         default: begin
            // Undefined mode: the fan holds and the status reads disabled.
            run_next = running;
            status   = STATUS_DISABLED;
         end
      endcase
   end

   assign state_next.fan_running       = run_next;
   assign state_next.high_ambient_mode = amb_high;

   assign result.fan_drive    = run_next;
   assign result.high_ambient = amb_high;
   assign result.fan_status   = word.fan_enabled ? status : STATUS_DISABLED;

endmodule

// ===== rtl/chassis_fan_hysteresis_control.sv =====
// Chassis fan controller with ambient hysteresis, one word per periodic tick.
// The req_ channel carries one sensor word (speed, engine and ambient
// temperature, engine state, mode, force and enable bits); the rsp_ channel
// returns one word per request: the fan drive, the ambient flag and a status
// code. Both channels use valid/ready.
// Thresholds are set through the csr_ write port: csr_we writes csr_wdata to
// the register at csr_index in the same cycle. Write only while idle.
// The request is captured in an input register, then the compares and the fan
// decision run into the response register, which also updates the fan and
// ambient state; response valid rises when a word moves into that register.
// The block takes one word per cycle while the receiver keeps rsp_ready high.
// When the receiver stalls, the response holds, the input register fills,
// and then req_ready drops until the response is taken.
// Synchronous reset clears both valid flags, turns the fan off, clears the
// ambient flag and loads the default thresholds.
module chassis_fan_hysteresis_control
   import chfan_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [DataWidth-1:0] csr_wdata
);

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   state_type state_ff;
   state_type state_in;
   req_type   word_ff;
   logic      word_valid_ff;
   logic      word_valid_in;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      rsp_free;
   logic      word_move;
   logic      req_take;

   chfan_step u_step (
      .word       (word_ff),
      .cfg        (cfg_ff),
      .state      (state_ff),
      .state_next (state_in),
      .result     (rsp_in)
   );

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign word_move = word_valid_ff && rsp_free;
   assign req_ready = !word_valid_ff || word_move;
   assign req_take  = req_valid && req_ready;

   assign word_valid_in = req_take || (word_valid_ff && !word_move);
   assign rsp_valid_in  = word_move || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_LOW_AMBIENT_THRESHOLD:  cfg_in.low_ambient_threshold  = csr_wdata;
            REG_HIGH_AMBIENT_THRESHOLD: cfg_in.high_ambient_threshold = csr_wdata;
            REG_ENABLE_BELOW_SPEED:     cfg_in.enable_below_speed     = csr_wdata;
            REG_DISABLE_ABOVE_SPEED:    cfg_in.disable_above_speed    = csr_wdata;
            REG_LOW_AMB_ON_TEMP:        cfg_in.low_amb_on_temp        = csr_wdata;
            REG_HIGH_AMB_ON_TEMP:       cfg_in.high_amb_on_temp       = csr_wdata;
            REG_LOW_AMB_OFF_TEMP:       cfg_in.low_amb_off_temp       = csr_wdata;
            REG_HIGH_AMB_OFF_TEMP:      cfg_in.high_amb_off_temp      = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_ambient_threshold  <= RST_LOW_AMBIENT_THRESHOLD;
         cfg_ff.high_ambient_threshold <= RST_HIGH_AMBIENT_THRESHOLD;
         cfg_ff.enable_below_speed     <= RST_ENABLE_BELOW_SPEED;
         cfg_ff.disable_above_speed    <= RST_DISABLE_ABOVE_SPEED;
         cfg_ff.low_amb_on_temp        <= RST_LOW_AMB_ON_TEMP;
         cfg_ff.high_amb_on_temp       <= RST_HIGH_AMB_ON_TEMP;
         cfg_ff.low_amb_off_temp       <= RST_LOW_AMB_OFF_TEMP;
         cfg_ff.high_amb_off_temp      <= RST_HIGH_AMB_OFF_TEMP;
         state_ff                      <= '0;
         word_valid_ff                 <= 1'b0;
         rsp_valid_ff                  <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         word_valid_ff <= word_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         // The state advances only when a word moves into the response register.
         if (word_move) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         word_ff <= req_data;
      end
      if (word_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sim/chassis_fan_tick_monitor.sv =====
`timescale 1ns / 100ps

module chassis_fan_tick_monitor
   import chfan_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [DataWidth-1:0] csr_wdata,
   output int                   fail_count,
   output int                   words_pending
);

   localparam cfg_type DefaultBands = '{
      low_ambient_threshold:  RST_LOW_AMBIENT_THRESHOLD,
      high_ambient_threshold: RST_HIGH_AMBIENT_THRESHOLD,
      enable_below_speed:     RST_ENABLE_BELOW_SPEED,
      disable_above_speed:    RST_DISABLE_ABOVE_SPEED,
      low_amb_on_temp:        RST_LOW_AMB_ON_TEMP,
      high_amb_on_temp:       RST_HIGH_AMB_ON_TEMP,
      low_amb_off_temp:       RST_LOW_AMB_OFF_TEMP,
      high_amb_off_temp:      RST_HIGH_AMB_OFF_TEMP
   };

   cfg_type bands = DefaultBands;
   logic    fan_on = 1'b0;
   logic    amb_hot = 1'b0;
   rsp_type fan_words_due[$];

   initial begin
      fail_count = 0;
      words_pending = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want_v);
      $display("mismatch at %0t ns: %s is %0d, should be %0d", $time, what, got, want_v);
      fail_count++;
   endtask

   // Advances the fan and ambient state by one tick and returns the word it produces.
   function automatic rsp_type next_fan_word(input req_type w);
      rsp_type r;
      logic signed [DataWidth-1:0] on_t;
      logic signed [DataWidth-1:0] off_t;
      logic slow, fast, hot, cool;
      if ($signed(w.ambient_temp) >= $signed(bands.high_ambient_threshold))
         amb_hot = 1'b1;
      else if ($signed(w.ambient_temp) < $signed(bands.low_ambient_threshold))
         amb_hot = 1'b0;
      on_t  = amb_hot ? bands.high_amb_on_temp : bands.low_amb_on_temp;
      off_t = amb_hot ? bands.high_amb_off_temp : bands.low_amb_off_temp;
      slow = w.vehicle_speed < bands.enable_below_speed;
      fast = w.vehicle_speed >= bands.disable_above_speed;
      hot  = $signed(w.engine_temp) > on_t;
      cool = $signed(w.engine_temp) <= off_t;
      case (w.fan_mode)
         MODE_OFF: begin
            fan_on = w.force_on & w.fan_enabled;
            r.fan_status = STATUS_OFF;
         end
         MODE_ON: begin
            if ((slow && !fan_on && w.engine_active) || w.force_on)
               fan_on = 1'b1;
            else if (fan_on && (fast || !w.engine_active))
               fan_on = 1'b0;
            r.fan_status = STATUS_ON;
         end
         MODE_AUTO: begin
            if ((slow && hot && !fan_on) || w.force_on)
               fan_on = 1'b1;
            else if (fan_on && (fast || cool || !w.engine_active))
               fan_on = 1'b0;
            r.fan_status = STATUS_AUTO;
         end
         default: begin
            // The undefined mode leaves the fan as it is.
            r.fan_status = STATUS_DISABLED;
         end
      endcase
      if (!w.fan_enabled)
         r.fan_status = STATUS_DISABLED;
      r.fan_drive = fan_on;
      r.high_ambient = amb_hot;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         bands = DefaultBands;
         fan_on = 1'b0;
         amb_hot = 1'b0;
         fan_words_due.delete();
      end else begin
         // Responses first: a word accepted on this edge cannot belong to a request
         // accepted on the same edge.
         if (rsp_valid && rsp_ready) begin
            if (fan_words_due.size() == 0) begin
               report_mismatch("response word with none due", rsp_data, 0);
            end else begin
               want = fan_words_due.pop_front();
               if (rsp_data.fan_drive !== want.fan_drive)
                  report_mismatch("fan_drive", rsp_data.fan_drive, want.fan_drive);
               if (rsp_data.high_ambient !== want.high_ambient)
                  report_mismatch("high_ambient", rsp_data.high_ambient, want.high_ambient);
               if (rsp_data.fan_status !== want.fan_status)
                  report_mismatch("fan_status", rsp_data.fan_status, want.fan_status);
            end
         end
         if (req_valid && req_ready)
            fan_words_due.push_back(next_fan_word(req_data));
         if (csr_we) begin
            case (csr_index)
               REG_LOW_AMBIENT_THRESHOLD:  bands.low_ambient_threshold = csr_wdata;
               REG_HIGH_AMBIENT_THRESHOLD: bands.high_ambient_threshold = csr_wdata;
               REG_ENABLE_BELOW_SPEED:     bands.enable_below_speed = csr_wdata;
               REG_DISABLE_ABOVE_SPEED:    bands.disable_above_speed = csr_wdata;
               REG_LOW_AMB_ON_TEMP:        bands.low_amb_on_temp = csr_wdata;
               REG_HIGH_AMB_ON_TEMP:       bands.high_amb_on_temp = csr_wdata;
               REG_LOW_AMB_OFF_TEMP:       bands.low_amb_off_temp = csr_wdata;
               REG_HIGH_AMB_OFF_TEMP:      bands.high_amb_off_temp = csr_wdata;
               default: ;
            endcase
         end
      end
      words_pending = fan_words_due.size();
   end

endmodule

// ===== sim/chassis_fan_hysteresis_control_tb.sv =====
`timescale 1ns / 100ps

module chassis_fan_hysteresis_control_tb;
   import chfan_pkg::*;

   localparam logic [1:0] MODE_UNDEFINED = 2'd3;
   localparam int CycleLimit = 400000;
   localparam int LongHoldCycles = 64;
   localparam int WordsPerPhase = 130;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [2:0]           csr_index;
   logic [DataWidth-1:0] csr_wdata;
   int                   fail_count;
   int                   words_pending;

   int      cycles = 0;
   bit      steady = 1'b0;
   int      hold_asks = 0;
   int      hold_served = 0;
   cfg_type cur_cfg;
   int      walk_speed = 600;
   int      walk_eng = 850;
   int      walk_amb = 320;
   logic [1:0] walk_mode = MODE_AUTO;

   chassis_fan_hysteresis_control u_top (.*);

   chassis_fan_tick_monitor u_monitor (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("chassis_fan_hysteresis_control regression: fail");
         $finish;
      end
   end

   function automatic int idle_len();
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   // Receiver: random stalls, plus one long hold-off whenever the stimulus asks for it.
   initial begin
      int n;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != hold_served) begin
            hold_served = hold_asks;
            rsp_ready <= 1'b0;
            repeat (LongHoldCycles) @(negedge clock);
         end else begin
            n = idle_len();
            if (n > 0) begin
               rsp_ready <= 1'b0;
               repeat (n) @(negedge clock);
            end
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic int clamp_int(input int v, input int lo, input int hi);
      if (v < lo)
         return lo;
      if (v > hi)
         return hi;
      return v;
   endfunction

   function automatic int min_int(input int a, input int b);
      return (a < b) ? a : b;
   endfunction

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   // Random walk that stays in a band around two thresholds, with an occasional jump.
   function automatic int walk_step(input int v, input int a, input int b, input int margin,
                                    input int step, input int floor_v, input int ceil_v);
      int lo, hi;
      lo = clamp_int(min_int(a, b) - margin, floor_v, ceil_v);
      hi = clamp_int(max_int(a, b) + margin, floor_v, ceil_v);
      if ($urandom_range(0, 9) == 0)
         return lo + int'($urandom_range(0, hi - lo));
      return clamp_int(v + int'($urandom_range(0, 2 * step)) - step, lo, hi);
   endfunction

   function automatic req_type make_word(input int speed, input int eng, input int amb,
                                         input bit act, input logic [1:0] mode,
                                         input bit frc, input bit en);
      req_type w;
      w.vehicle_speed = 12'(speed);
      w.engine_temp   = 12'(eng);
      w.ambient_temp  = 12'(amb);
      w.engine_active = act;
      w.fan_mode      = mode;
      w.force_on      = frc;
      w.fan_enabled   = en;
      return w;
   endfunction

   // Mostly smooth sensor traces around the current bands; the rest is raw noise.
   function automatic req_type next_word(input bit wild);
      int t_lo, t_hi, r;
      if (wild)
         return make_word($urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 1),
                          2'($urandom_range(0, 3)), $urandom_range(0, 1),
                          $urandom_range(0, 1));
      t_lo = min_int(min_int($signed(cur_cfg.low_amb_on_temp), $signed(cur_cfg.high_amb_on_temp)),
                     min_int($signed(cur_cfg.low_amb_off_temp),
                             $signed(cur_cfg.high_amb_off_temp)));
      t_hi = max_int(max_int($signed(cur_cfg.low_amb_on_temp), $signed(cur_cfg.high_amb_on_temp)),
                     max_int($signed(cur_cfg.low_amb_off_temp),
                             $signed(cur_cfg.high_amb_off_temp)));
      walk_speed = walk_step(walk_speed, int'(cur_cfg.enable_below_speed),
                             int'(cur_cfg.disable_above_speed), 60, 25, 0, 4095);
      walk_eng = walk_step(walk_eng, t_lo, t_hi, 60, 20, -2048, 2047);
      walk_amb = walk_step(walk_amb, $signed(cur_cfg.low_ambient_threshold),
                           $signed(cur_cfg.high_ambient_threshold), 40, 10, -2048, 2047);
      if ($urandom_range(0, 9) == 0) begin
         r = $urandom_range(0, 19);
         if (r < 12)
            walk_mode = MODE_AUTO;
         else if (r < 16)
            walk_mode = MODE_ON;
         else if (r < 18)
            walk_mode = MODE_OFF;
         else
            walk_mode = MODE_UNDEFINED;
      end
      return make_word(walk_speed, walk_eng, walk_amb, $urandom_range(0, 9) != 0, walk_mode,
                       $urandom_range(0, 11) == 0, $urandom_range(0, 19) != 0);
   endfunction

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_word(input req_type w, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic settle(input int tail);
      while (words_pending != 0)
         @(negedge clock);
      repeat (tail) @(negedge clock);
   endtask

   task automatic load_config(input cfg_type c);
      logic [DataWidth-1:0] v;
      for (int i = 0; i < 8; i++) begin
         case (3'(i))
            REG_LOW_AMBIENT_THRESHOLD:  v = c.low_ambient_threshold;
            REG_HIGH_AMBIENT_THRESHOLD: v = c.high_ambient_threshold;
            REG_ENABLE_BELOW_SPEED:     v = c.enable_below_speed;
            REG_DISABLE_ABOVE_SPEED:    v = c.disable_above_speed;
            REG_LOW_AMB_ON_TEMP:        v = c.low_amb_on_temp;
            REG_HIGH_AMB_ON_TEMP:       v = c.high_amb_on_temp;
            REG_LOW_AMB_OFF_TEMP:       v = c.low_amb_off_temp;
            default:                    v = c.high_amb_off_temp;
         endcase
         csr_we <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= v;
         @(negedge clock);
      end
      csr_we <= 1'b0;
      cur_cfg = c;
   endtask

   // Band settings per phase: in-range random, both range ends, raw bit extremes, raw random.
   function automatic cfg_type pick_cfg(input int kind);
      cfg_type c;
      int a, t;
      case (kind)
         1, 6: begin
            a = int'($urandom_range(0, 2400)) - 400;
            c.low_ambient_threshold  = 12'(a);
            c.high_ambient_threshold = 12'(min_int(a + int'($urandom_range(0, 200)), 2000));
            a = $urandom_range(0, 4000);
            c.enable_below_speed  = 12'(a);
            c.disable_above_speed = 12'(min_int(a + int'($urandom_range(0, 300)), 4000));
            t = int'($urandom_range(0, 2400)) - 400;
            c.low_amb_on_temp  = 12'(t);
            c.low_amb_off_temp = 12'(max_int(t - int'($urandom_range(0, 300)), -400));
            t = int'($urandom_range(0, 2400)) - 400;
            c.high_amb_on_temp  = 12'(t);
            c.high_amb_off_temp = 12'(max_int(t - int'($urandom_range(0, 300)), -400));
         end
         2: c = '{12'(-400), 12'(-400), 12'd0, 12'd0,
                  12'(-400), 12'(-400), 12'(-400), 12'(-400)};
         3: c = '{12'(2000), 12'(2000), 12'd4000, 12'd4000,
                  12'(2000), 12'(2000), 12'(2000), 12'(2000)};
         4: begin
            c = {$urandom, $urandom, $urandom};
            c.low_ambient_threshold  = $urandom_range(0, 1) ? 12'h7FF : 12'h800;
            c.high_ambient_threshold = $urandom_range(0, 1) ? 12'h7FF : 12'h800;
            c.enable_below_speed     = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            c.disable_above_speed    = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            c.low_amb_on_temp        = $urandom_range(0, 1) ? 12'h7FF : 12'h800;
            c.high_amb_on_temp       = $urandom_range(0, 1) ? 12'h7FF : 12'h800;
            c.low_amb_off_temp       = $urandom_range(0, 1) ? 12'h7FF : 12'h800;
            c.high_amb_off_temp      = $urandom_range(0, 1) ? 12'h7FF : 12'h800;
         end
         default: c = {$urandom, $urandom, $urandom};
      endcase
      return c;
   endfunction

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cur_cfg = '{RST_LOW_AMBIENT_THRESHOLD, RST_HIGH_AMBIENT_THRESHOLD,
                  RST_ENABLE_BELOW_SPEED, RST_DISABLE_ABOVE_SPEED,
                  RST_LOW_AMB_ON_TEMP, RST_HIGH_AMB_ON_TEMP,
                  RST_LOW_AMB_OFF_TEMP, RST_HIGH_AMB_OFF_TEMP};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words against the reset bands.
      send_word(make_word(0, 0, 0, 1, MODE_OFF, 0, 0), 0);
      send_word(make_word(0, 0, 0, 1, MODE_OFF, 1, 0), 0);
      send_word(make_word(0, 0, 0, 1, MODE_OFF, 0, 1), 0);
      send_word(make_word(0, 0, 0, 1, MODE_OFF, 1, 1), 0);
      send_word(make_word(4095, 0, 0, 1, MODE_ON, 0, 1), 0);
      send_word(make_word(0, 0, 0, 0, MODE_ON, 0, 1), 0);
      send_word(make_word(0, 0, 0, 1, MODE_ON, 0, 1), 0);
      send_word(make_word(700, 0, 0, 1, MODE_ON, 0, 1), 0);
      send_word(make_word(700, 0, 0, 0, MODE_ON, 0, 1), 0);
      // Hot ambient selects the lower band pair, then holds inside the hysteresis gap.
      send_word(make_word(100, 950, 2047, 1, MODE_AUTO, 0, 1), 0);
      send_word(make_word(100, 781, 320, 1, MODE_AUTO, 0, 1), 0);
      send_word(make_word(100, 780, 320, 1, MODE_AUTO, 0, 1), 0);
      send_word(make_word(100, 951, -2048, 1, MODE_AUTO, 0, 1), 0);
      send_word(make_word(639, 821, 299, 1, MODE_AUTO, 0, 1), 0);
      send_word(make_word(719, 821, 350, 1, MODE_AUTO, 0, 1), 0);
      send_word(make_word(100, 820, 349, 1, MODE_AUTO, 0, 1), 0);
      send_word(make_word(4095, -2048, 0, 0, MODE_AUTO, 1, 1), 0);
      send_word(make_word(4095, -2048, 0, 1, MODE_AUTO, 0, 1), 0);
      send_word(make_word(0, 2047, 0, 1, MODE_UNDEFINED, 1, 1), 0);
      send_word(make_word(0, 0, 0, 1, MODE_AUTO, 1, 1), 0);
      send_word(make_word(4095, -2048, -1, 0, MODE_UNDEFINED, 0, 1), 0);
      send_word(make_word(720, 2047, 0, 1, MODE_AUTO, 0, 0), 0);
      send_word(make_word(4095, 2047, 2047, 1, MODE_ON, 1, 0), 0);

      for (int phase = 1; phase <= 6; phase++) begin
         req_valid <= 1'b0;
         settle(4);
         load_config(pick_cfg(phase));
         steady = (phase == 3);
         for (int n = 0; n < WordsPerPhase; n++) begin
            // The sender keeps going while the receiver sits out a long hold-off.
            if (phase == 2 && n == 30)
               hold_asks++;
            if (phase == 4 && n == 60) begin
               req_valid <= 1'b0;
               settle(0);
            end
            send_word(next_word($urandom_range(0, 4) == 0), idle_len());
         end
      end
      req_valid <= 1'b0;
      steady = 1'b0;
      settle(16);
      if (fail_count == 0)
         $display("chassis_fan_hysteresis_control regression: pass");
      else
         $display("chassis_fan_hysteresis_control regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/chfan_pkg.sv
rtl/chfan_step.sv
rtl/chassis_fan_hysteresis_control.sv
sim/chassis_fan_tick_monitor.sv
sim/chassis_fan_hysteresis_control_tb.sv
